>>> design/cdc_pkg.sv
// Shared constants and calendar tables for the calendar date converter.
package cdc_pkg;

    localparam int YEAR_BITS_DEF = 12;

    localparam int SEQ_BITS   = 9;
    localparam int MONTH_BITS = 4;
    localparam int DAY_BITS   = 5;
    localparam int WEEK_BITS  = 6;
    localparam int WDAY_BITS  = 3;
    localparam int TOTAL_MONTHS = 12;

    localparam int BASE_YEAR = 1900;
    // BASE_YEAR plus the 460 leap years up to 1899: offset of the day count mod 7
    localparam int DAYS_BIAS = 2360;
    localparam int LEAP_YEAR_DAYS   = 366;
    localparam int COMMON_YEAR_DAYS = 365;

    localparam int DIV_25 = 25;
    // floor(x / 25) = (x * DIV25_MUL) >> DIV25_SHIFT, exact for x below 43690
    localparam int DIV25_MUL   = 5243;
    localparam int DIV25_SHIFT = 17;
    localparam int DIV25_BITS  = 13;

    localparam int DAYS_IN_WEEK = 7;
    // floor(x / 7) = (x * DIV7_MUL) >> DIV7_SHIFT, exact for x below 682
    localparam int DIV7_MUL   = 586;
    localparam int DIV7_SHIFT = 12;
    localparam int DIV7_BITS  = 10;
    localparam int FIRST_WEEKEND_DAY = 5;

    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] mon,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    // Days of the year that come before the first of the month.
    function automatic logic [SEQ_BITS-1:0] days_before(input logic [MONTH_BITS-1:0] mon,
                                                        input logic leap);
        logic [SEQ_BITS-1:0] base;
        unique case (mon)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (mon > 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

    // Residue mod 7 by folding octal digits, since 8 is 1 mod 7.
    function automatic logic [WDAY_BITS-1:0] mod7(input logic [32:0] v);
        logic [6:0] s;
        logic [3:0] f;
        logic [3:0] g;
        s = '0;
        for (int i = 0; i < 11; i++) begin
            s = s + 7'(v[3*i +: 3]);
        end
        f = 4'(s[2:0]) + 4'(s[5:3]) + 4'(s[6]);
        g = 4'(f[2:0]) + 4'(f[3]);
        return (g >= 4'(DAYS_IN_WEEK)) ? 3'(g - 4'(DAYS_IN_WEEK)) : g[2:0];
    endfunction

endpackage

>>> design/calendar_date_converter.sv
// Pipelined Gregorian date converter: day of year, month, day, week and weekday.
//
//  channel   | ports                                      | handshake
//  ----------+--------------------------------------------+---------------------------
//  request   | i_command i_year i_month i_day             | start high, busy low
//            | i_day_of_year                              |
//  result    | o_seq_of_year o_out_month o_out_day        | o_done high for one cycle
//            | o_week_of_year o_weekday o_is_weekend      |
//            | o_is_leap o_error                          |
//
// Five register stages: century divides, leap and day count, date conversion
// and weekday of January 1, position in the year, divide by seven.
// One request per cycle; each result passes through all five register stages.
// busy stays low: the pipeline never stalls and the receiver takes each
// result in the cycle that o_done marks it.
// i_rst_n (synchronous) drops every request in flight.
module calendar_date_converter
    import cdc_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [YEAR_BITS-1:0]  i_year,
    input  logic [MONTH_BITS-1:0] i_month,
    input  logic [DAY_BITS-1:0]   i_day,
    input  logic [SEQ_BITS-1:0]   i_day_of_year,
    output logic                  o_done,
    output logic [SEQ_BITS-1:0]   o_seq_of_year,
    output logic [MONTH_BITS-1:0] o_out_month,
    output logic [DAY_BITS-1:0]   o_out_day,
    output logic [WEEK_BITS-1:0]  o_week_of_year,
    output logic [WDAY_BITS-1:0]  o_weekday,
    output logic                  o_is_weekend,
    output logic                  o_is_leap,
    output logic                  o_error
);

    localparam int QB     = YEAR_BITS - 2;
    localparam int QB16   = YEAR_BITS - 4;
    localparam int P100_W = QB + DIV25_BITS;
    localparam int P400_W = QB16 + DIV25_BITS;
    localparam int M25_W  = QB + 5;
    localparam int TW     = YEAR_BITS + 1;
    localparam int P7_W   = SEQ_BITS + DIV7_BITS;

    // ---------------- stage 1: divide year by 100 and by 400
    logic [P100_W-1:0] p100;
    logic [P400_W-1:0] p400;

    logic                  r_v1, n_v1;
    logic                  r_cmd1;
    logic [YEAR_BITS-1:0]  r_year1;
    logic [MONTH_BITS-1:0] r_mon1;
    logic [DAY_BITS-1:0]   r_day1;
    logic [SEQ_BITS-1:0]   r_doy1;
    logic [QB-1:0]         r_q100_1, n_q100_1;
    logic [QB-1:0]         r_q400_1, n_q400_1;

    assign busy = 1'b0;
    assign n_v1 = start & ~busy;

    always_comb begin
        p100     = P100_W'(i_year[YEAR_BITS-1:2]) * P100_W'(DIV25_MUL);
        p400     = P400_W'(i_year[YEAR_BITS-1:4]) * P400_W'(DIV25_MUL);
        n_q100_1 = QB'(p100 >> DIV25_SHIFT);
        n_q400_1 = QB'(p400 >> DIV25_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
        r_cmd1   <= i_command;
        r_year1  <= i_year;
        r_mon1   <= i_month;
        r_day1   <= i_day;
        r_doy1   <= i_day_of_year;
        r_q100_1 <= n_q100_1;
        r_q400_1 <= n_q400_1;
    end

    // ---------------- stage 2: leap flag and day count since 1900 (mod 7 later)
    logic [M25_W-1:0] m100;
    logic [M25_W-1:0] m400;
    logic             div4, div100, div400;

    logic                  r_v2;
    logic                  r_cmd2;
    logic [MONTH_BITS-1:0] r_mon2;
    logic [DAY_BITS-1:0]   r_day2;
    logic [SEQ_BITS-1:0]   r_doy2;
    logic                  r_leap2, n_leap2;
    logic [TW-1:0]         r_t2, n_t2;
    logic                  r_pre2, n_pre2;

    always_comb begin
        m100    = M25_W'(r_q100_1) * M25_W'(DIV_25);
        m400    = M25_W'(r_q400_1) * M25_W'(DIV_25);
        div4    = (r_year1[1:0] == 2'b00);
        div100  = div4 && (m100 == M25_W'(r_year1[YEAR_BITS-1:2]));
        div400  = (r_year1[3:0] == 4'b0000) && (m400 == M25_W'(r_year1[YEAR_BITS-1:4]));
        n_leap2 = (div4 && !div100) || div400;
        // leaps through year-1 = y/4 - y/100 + y/400 - leap(y); 365 is 1 mod 7
        n_t2    = TW'(r_year1) + TW'(r_year1[YEAR_BITS-1:2]) + TW'(r_q400_1)
                - TW'(r_q100_1) - TW'(n_leap2) - TW'(DAYS_BIAS);
        n_pre2  = (r_year1 < YEAR_BITS'(BASE_YEAR));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_cmd2  <= r_cmd1;
        r_mon2  <= r_mon1;
        r_day2  <= r_day1;
        r_doy2  <= r_doy1;
        r_leap2 <= n_leap2;
        r_t2    <= n_t2;
        r_pre2  <= n_pre2;
    end

    // ---------------- stage 3: date conversion, checks, weekday of January 1
    logic [DAY_BITS-1:0]   mlen;
    logic [SEQ_BITS-1:0]   ylen;
    logic [MONTH_BITS-1:0] srch_mon;
    logic                  bad_md, bad_doy;

    logic                  r_v3;
    logic                  r_err3, n_err3;
    logic [SEQ_BITS-1:0]   r_seq3, n_seq3;
    logic [MONTH_BITS-1:0] r_mon3, n_mon3;
    logic [DAY_BITS-1:0]   r_day3, n_day3;
    logic                  r_leap3;
    logic [WDAY_BITS-1:0]  r_j1_3, n_j1_3;

    always_comb begin
        mlen    = month_len(r_mon2, r_leap2);
        ylen    = r_leap2 ? SEQ_BITS'(LEAP_YEAR_DAYS) : SEQ_BITS'(COMMON_YEAR_DAYS);
        bad_md  = (r_mon2 == '0) || (r_mon2 > MONTH_BITS'(TOTAL_MONTHS))
               || (r_day2 == '0) || (r_day2 > mlen);
        bad_doy = (r_doy2 == '0) || (r_doy2 > ylen);
        // last month whose first day is not past the requested day wins
        srch_mon = MONTH_BITS'(1);
        for (int i = 1; i < TOTAL_MONTHS; i++) begin
            if (r_doy2 > days_before(MONTH_BITS'(i + 1), r_leap2) + SEQ_BITS'(0)) begin
                srch_mon = MONTH_BITS'(i + 1);
            end
        end
        if (r_cmd2) begin
            n_err3 = bad_doy;
            n_seq3 = r_doy2;
            n_mon3 = srch_mon;
            n_day3 = DAY_BITS'(r_doy2 - days_before(srch_mon, r_leap2));
        end else begin
            n_err3 = bad_md;
            n_seq3 = days_before(r_mon2, r_leap2) + SEQ_BITS'(r_day2);
            n_mon3 = r_mon2;
            n_day3 = r_day2;
        end
        n_j1_3 = r_pre2 ? '0 : mod7(33'(r_t2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_err3  <= n_err3;
        r_seq3  <= n_seq3;
        r_mon3  <= n_mon3;
        r_day3  <= n_day3;
        r_leap3 <= r_leap2;
        r_j1_3  <= n_j1_3;
    end

    // ---------------- stage 4: position counted from the Monday on or before Jan 1
    logic                  r_v4;
    logic                  r_err4;
    logic [SEQ_BITS-1:0]   r_seq4;
    logic [MONTH_BITS-1:0] r_mon4;
    logic [DAY_BITS-1:0]   r_day4;
    logic                  r_leap4;
    logic [SEQ_BITS-1:0]   r_pos4, n_pos4;

    assign n_pos4 = r_seq3 + SEQ_BITS'(r_j1_3) - SEQ_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_err4  <= r_err3;
        r_seq4  <= r_seq3;
        r_mon4  <= r_mon3;
        r_day4  <= r_day3;
        r_leap4 <= r_leap3;
        r_pos4  <= n_pos4;
    end

    // ---------------- stage 5: week and weekday, zero the fields on error
    logic [P7_W-1:0]      p7;
    logic [WEEK_BITS-1:0] q7;
    logic [SEQ_BITS-1:0]  rem7;

    logic                  r_done;
    logic [SEQ_BITS-1:0]   r_seq5, n_seq5;
    logic [MONTH_BITS-1:0] r_mon5, n_mon5;
    logic [DAY_BITS-1:0]   r_day5, n_day5;
    logic [WEEK_BITS-1:0]  r_week5, n_week5;
    logic [WDAY_BITS-1:0]  r_wday5, n_wday5;
    logic                  r_wend5, n_wend5;
    logic                  r_leap5, n_leap5;
    logic                  r_err5;

    always_comb begin
        p7   = P7_W'(r_pos4) * P7_W'(DIV7_MUL);
        q7   = WEEK_BITS'(p7 >> DIV7_SHIFT);
        rem7 = r_pos4 - SEQ_BITS'(SEQ_BITS'(q7) * SEQ_BITS'(DAYS_IN_WEEK));
        if (r_err4) begin
            n_seq5  = '0;
            n_mon5  = '0;
            n_day5  = '0;
            n_week5 = '0;
            n_wday5 = '0;
            n_wend5 = 1'b0;
            n_leap5 = 1'b0;
        end else begin
            n_seq5  = r_seq4;
            n_mon5  = r_mon4;
            n_day5  = r_day4;
            n_week5 = q7 + WEEK_BITS'(1);
            n_wday5 = WDAY_BITS'(rem7);
            n_wend5 = (WDAY_BITS'(rem7) >= WDAY_BITS'(FIRST_WEEKEND_DAY));
            n_leap5 = r_leap4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v4;
        end
        r_seq5  <= n_seq5;
        r_mon5  <= n_mon5;
        r_day5  <= n_day5;
        r_week5 <= n_week5;
        r_wday5 <= n_wday5;
        r_wend5 <= n_wend5;
        r_leap5 <= n_leap5;
        r_err5  <= r_err4;
    end

    assign o_done         = r_done;
    assign o_seq_of_year  = r_seq5;
    assign o_out_month    = r_mon5;
    assign o_out_day      = r_day5;
    assign o_week_of_year = r_week5;
    assign o_weekday      = r_wday5;
    assign o_is_weekend   = r_wend5;
    assign o_is_leap      = r_leap5;
    assign o_error        = r_err5;

    // ---------------- checks
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_done)
        else $error("request did not produce a result five cycles later");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 5))
        else $error("result without a matching request");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_error) |-> (o_seq_of_year == '0 && o_out_month == '0
                                 && o_out_day == '0 && !o_is_leap && !o_is_weekend))
        else $error("error result carries nonzero fields");

    a_good_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_error) |-> (o_out_month != '0 && o_out_month <= 4'd12
                                  && o_out_day != '0 && o_weekday <= 3'd6
                                  && o_week_of_year != '0))
        else $error("valid result out of calendar range");

endmodule

>>> dv/cdc_tb_pkg.sv
// Request command codes shared by the calendar date converter testbench files.
package cdc_tb_pkg;

    typedef enum logic {
        CMD_MONTH_DAY   = 1'b0,
        CMD_DAY_OF_YEAR = 1'b1
    } t_date_cmd;

endpackage

>>> dv/calendar_date_checker.sv
// Checker for the calendar date converter: predicts each date request and compares results.
module calendar_date_checker
    import cdc_pkg::*;
    import cdc_tb_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  logic                  i_command,
    input  logic [YEAR_BITS-1:0]  i_year,
    input  logic [MONTH_BITS-1:0] i_month,
    input  logic [DAY_BITS-1:0]   i_day,
    input  logic [SEQ_BITS-1:0]   i_day_of_year,
    input  logic                  i_done,
    input  logic [SEQ_BITS-1:0]   i_seq_of_year,
    input  logic [MONTH_BITS-1:0] i_out_month,
    input  logic [DAY_BITS-1:0]   i_out_day,
    input  logic [WEEK_BITS-1:0]  i_week_of_year,
    input  logic [WDAY_BITS-1:0]  i_weekday,
    input  logic                  i_is_weekend,
    input  logic                  i_is_leap,
    input  logic                  i_error,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 10;
    // leap years in 1..1899
    localparam int unsigned LEAPS_BEFORE_BASE = 460;

    typedef struct packed {
        logic [SEQ_BITS-1:0]   seq_of_year;
        logic [MONTH_BITS-1:0] out_month;
        logic [DAY_BITS-1:0]   out_day;
        logic [WEEK_BITS-1:0]  week_of_year;
        logic [WDAY_BITS-1:0]  weekday;
        logic                  is_weekend;
        logic                  is_leap;
        logic                  error;
    } t_date_result;

    t_date_result expected_dates[$];

    function automatic int unsigned month_days(input int unsigned mon, input bit leap);
        int unsigned len;
        unique case (mon)
            2:           len = leap ? 29 : 28;
            4, 6, 9, 11: len = 30;
            default:     len = 31;
        endcase
        return len;
    endfunction

    function automatic t_date_result convert_date(input logic cmd, input int unsigned yr,
                                                  input int unsigned mon, input int unsigned dd,
                                                  input int unsigned doy);
        t_date_result res;
        int unsigned  year_len;
        int unsigned  acc;
        int unsigned  seq;
        int unsigned  mo;
        int unsigned  dm;
        int unsigned  jan1;
        int unsigned  pos;
        int unsigned  i;
        bit           leap;
        bit           bad;
        res  = '0;
        leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
        year_len = leap ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
        bad  = 1'b0;
        acc  = 0;
        seq  = 0;
        mo   = 0;
        dm   = 0;
        if (cmd == CMD_MONTH_DAY) begin
            if (mon < 1 || mon > TOTAL_MONTHS || dd < 1 || dd > month_days(mon, leap)) begin
                bad = 1'b1;
            end else begin
                for (i = 1; i < mon; i++) begin
                    acc += month_days(i, leap);
                end
                seq = acc + dd;
                mo  = mon;
                dm  = dd;
            end
        end else begin
            if (doy < 1 || doy > year_len) begin
                bad = 1'b1;
            end else begin
                mo = 1;
                while (acc + month_days(mo, leap) < doy) begin
                    acc += month_days(mo, leap);
                    mo++;
                end
                seq = doy;
                dm  = doy - acc;
            end
        end
        if (bad) begin
            res.error = 1'b1;
            return res;
        end
        // years before the base take Monday for January 1
        jan1 = 0;
        if (yr >= BASE_YEAR) begin
            jan1 = (COMMON_YEAR_DAYS * (yr - BASE_YEAR) + (yr - 1) / 4 - (yr - 1) / 100
                    + (yr - 1) / 400 - LEAPS_BEFORE_BASE) % DAYS_IN_WEEK;
        end
        pos = seq + jan1 - 1;
        res.seq_of_year  = SEQ_BITS'(seq);
        res.out_month    = MONTH_BITS'(mo);
        res.out_day      = DAY_BITS'(dm);
        res.week_of_year = WEEK_BITS'(pos / DAYS_IN_WEEK + 1);
        res.weekday      = WDAY_BITS'(pos % DAYS_IN_WEEK);
        res.is_weekend   = (pos % DAYS_IN_WEEK) >= FIRST_WEEKEND_DAY;
        res.is_leap      = leap;
        res.error        = 1'b0;
        return res;
    endfunction

    function automatic string show_date(input t_date_result r);
        return $sformatf("seq=%0d mon=%0d day=%0d week=%0d wday=%0d wend=%0b leap=%0b err=%0b",
                         r.seq_of_year, r.out_month, r.out_day, r.week_of_year, r.weekday,
                         r.is_weekend, r.is_leap, r.error);
    endfunction

    always @(posedge i_clk) begin
        t_date_result seen;
        t_date_result want;
        if (i_rst_n === 1'b1) begin
            if (i_done !== 1'b0) begin
                seen = {i_seq_of_year, i_out_month, i_out_day, i_week_of_year, i_weekday,
                        i_is_weekend, i_is_leap, i_error};
                if (expected_dates.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS) begin
                        $display("unexpected date result: %s", show_date(seen));
                    end
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_dates.pop_front();
                    if (seen.seq_of_year !== want.seq_of_year
                            || seen.out_month !== want.out_month
                            || seen.out_day !== want.out_day
                            || seen.week_of_year !== want.week_of_year
                            || seen.weekday !== want.weekday
                            || seen.is_weekend !== want.is_weekend
                            || seen.is_leap !== want.is_leap
                            || seen.error !== want.error) begin
                        if (o_fail_count < MAX_REPORTS) begin
                            $display("date mismatch at %0t", $realtime);
                            $display("  expected: %s", show_date(want));
                            $display("  actual:   %s", show_date(seen));
                        end
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                expected_dates.push_back(convert_date(i_command, i_year, i_month, i_day,
                                                      i_day_of_year));
            end
            o_pending = expected_dates.size();
        end
    end

endmodule

>>> dv/tb_calendar_date_converter.sv
// Testbench top for the calendar date converter: stimulus, watchdog and verdict.
module tb_calendar_date_converter;
    import cdc_pkg::*;
    import cdc_tb_pkg::*;

    localparam int YEAR_BITS    = YEAR_BITS_DEF;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_command;
    logic [YEAR_BITS-1:0]  i_year;
    logic [MONTH_BITS-1:0] i_month;
    logic [DAY_BITS-1:0]   i_day;
    logic [SEQ_BITS-1:0]   i_day_of_year;
    logic                  o_done;
    logic [SEQ_BITS-1:0]   o_seq_of_year;
    logic [MONTH_BITS-1:0] o_out_month;
    logic [DAY_BITS-1:0]   o_out_day;
    logic [WEEK_BITS-1:0]  o_week_of_year;
    logic [WDAY_BITS-1:0]  o_weekday;
    logic                  o_is_weekend;
    logic                  o_is_leap;
    logic                  o_error;

    int fail_count;
    int pending_dates;
    int idle_cycles;
    int burst_left;

    calendar_date_converter #(
        .YEAR_BITS(YEAR_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_command(i_command),
        .i_year(i_year),
        .i_month(i_month),
        .i_day(i_day),
        .i_day_of_year(i_day_of_year),
        .o_done(o_done),
        .o_seq_of_year(o_seq_of_year),
        .o_out_month(o_out_month),
        .o_out_day(o_out_day),
        .o_week_of_year(o_week_of_year),
        .o_weekday(o_weekday),
        .o_is_weekend(o_is_weekend),
        .o_is_leap(o_is_leap),
        .o_error(o_error)
    );

    calendar_date_checker #(
        .YEAR_BITS(YEAR_BITS)
    ) checker_i (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_command(i_command),
        .i_year(i_year),
        .i_month(i_month),
        .i_day(i_day),
        .i_day_of_year(i_day_of_year),
        .i_done(o_done),
        .i_seq_of_year(o_seq_of_year),
        .i_out_month(o_out_month),
        .i_out_day(o_out_day),
        .i_week_of_year(o_week_of_year),
        .i_weekday(o_weekday),
        .i_is_weekend(o_is_weekend),
        .i_is_leap(o_is_leap),
        .i_error(o_error),
        .o_fail_count(fail_count),
        .o_pending(pending_dates)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // End the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold one request on the ports until the converter takes it.
    task automatic send_date(input t_date_cmd cmd, input int unsigned yr,
                             input int unsigned mon, input int unsigned dd,
                             input int unsigned doy);
        i_command     <= cmd;
        i_year        <= YEAR_BITS'(yr);
        i_month       <= MONTH_BITS'(mon);
        i_day         <= DAY_BITS'(dd);
        i_day_of_year <= SEQ_BITS'(doy);
        start         <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Drop start and hold until every predicted date has come back.
    task automatic drain_results();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_dates != 0);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 40);
    endfunction

    function automatic int unsigned pick_year();
        int unsigned corner_years[8];
        corner_years = '{1900, 1899, 2000, 2012, 2100, 2400, 4000, 4095};
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 4095);
            1:       return corner_years[$urandom_range(0, 7)];
            default: return $urandom_range(BASE_YEAR, 4095);
        endcase
    endfunction

    task automatic send_random_date();
        int unsigned yr;
        int unsigned mon;
        int unsigned dd;
        int unsigned doy;
        int          r;
        yr  = pick_year();
        mon = $urandom_range(0, 15);
        dd  = $urandom_range(0, 31);
        doy = $urandom_range(0, 511);
        r   = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 0) begin
            // mostly real dates; day 29..31 still trips short months
            if (r < 88) begin
                mon = $urandom_range(1, TOTAL_MONTHS);
                dd  = (r < 60) ? $urandom_range(1, 28) : $urandom_range(1, 31);
            end
            send_date(CMD_MONTH_DAY, yr, mon, dd, doy);
        end else begin
            if (r < 85) begin
                doy = $urandom_range(1, COMMON_YEAR_DAYS);
            end else if (r < 92) begin
                doy = LEAP_YEAR_DAYS;
            end
            send_date(CMD_DAY_OF_YEAR, yr, mon, dd, doy);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_command     <= CMD_MONTH_DAY;
        i_year        <= '0;
        i_month       <= '0;
        i_day         <= '0;
        i_day_of_year <= '0;
        burst_left    = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_date(CMD_MONTH_DAY,   1900, 1, 1, 0);
        send_date(CMD_MONTH_DAY,   1900, 12, 31, 511);
        pause_sender(pick_gap());
        send_date(CMD_MONTH_DAY,   2000, 2, 29, 0);
        send_date(CMD_MONTH_DAY,   1900, 2, 29, 0);
        send_date(CMD_MONTH_DAY,   2100, 2, 29, 0);
        send_date(CMD_MONTH_DAY,   2400, 2, 29, 0);
        pause_sender(pick_gap());
        send_date(CMD_MONTH_DAY,   2023, 0, 15, 0);
        send_date(CMD_MONTH_DAY,   2023, 13, 1, 0);
        send_date(CMD_MONTH_DAY,   4095, 15, 31, 511);
        send_date(CMD_MONTH_DAY,   2023, 6, 0, 0);
        send_date(CMD_MONTH_DAY,   2023, 4, 31, 0);
        send_date(CMD_MONTH_DAY,   4095, 12, 31, 0);
        pause_sender(pick_gap());
        send_date(CMD_DAY_OF_YEAR, 2023, 15, 31, 0);
        send_date(CMD_DAY_OF_YEAR, 1900, 0, 0, 1);
        send_date(CMD_DAY_OF_YEAR, 2000, 0, 0, 366);
        send_date(CMD_DAY_OF_YEAR, 2001, 0, 0, 366);
        send_date(CMD_DAY_OF_YEAR, 2001, 15, 31, 511);
        send_date(CMD_DAY_OF_YEAR, 4095, 0, 0, 365);
        // years before 1900: Monday taken for January 1; 1899-02-29 is still an error
        send_date(CMD_MONTH_DAY,   0, 1, 1, 0);
        send_date(CMD_DAY_OF_YEAR, 1899, 0, 0, 60);
        send_date(CMD_MONTH_DAY,   1899, 2, 29, 0);
        // leap year starting on Sunday reaches week 54
        send_date(CMD_MONTH_DAY,   2012, 12, 31, 0);
        send_date(CMD_DAY_OF_YEAR, 2012, 0, 0, 366);
        send_date(CMD_DAY_OF_YEAR, 2012, 0, 0, 60);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_random_date();
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end else if (burst_left > 0) begin
                burst_left--;
            end else begin
                pause_sender(pick_gap());
                if ($urandom_range(0, 9) == 0) begin
                    burst_left = $urandom_range(20, 60);
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_dates == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
